// ----- hdl/pal_pkg.sv -----
// Package for the positional array list: payload words, request and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

   // Request kinds
   typedef enum logic [2:0] {
      KIND_APPEND     = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_INSERT_AT  = 3'd4,
      KIND_DELETE_AT  = 3'd5,
      KIND_SEARCH     = 3'd6,
      KIND_READ       = 3'd7
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Request word
   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   // Result word
   typedef struct packed {
      status_type         status;
      logic               found;
      logic signed [31:0] read_value;
      logic [6:0]         element_count;
   } rsp_type;

   // Load source for the pointer and target registers
   typedef enum logic [1:0] {
      SEL_COUNT = 2'd0,
      SEL_ZERO  = 2'd1,
      SEL_POSM1 = 2'd2
   } sel_type;

   // Memory read address source
   typedef enum logic [1:0] {
      RD_PTR_M1 = 2'd0,
      RD_PTR_P1 = 2'd1,
      RD_PTR    = 2'd2,
      RD_POSM1  = 2'd3
   } addr_sel_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_UP_TEST,
      S_UP_WR,
      S_DN_TEST,
      S_DN_WR,
      S_SC_TEST,
      S_SC_CMP,
      S_RD_WAIT,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         set_status;
      status_type   status_code;
      logic         tgt_load;
      sel_type      tgt_sel;
      logic         ptr_load;
      sel_type      ptr_sel;
      logic         ptr_inc;
      logic         ptr_dec;
      logic         mem_rd;
      addr_sel_type rd_sel;
      logic         mem_wr;
      logic         wr_value;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         cmp_en;
      logic         rd_capture;
      logic         rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     ins_pos_ok;
      logic     del_pos_ok;
      logic     ptr_gt_tgt;
      logic     ptr_p1_lt_cnt;
      logic     ptr_lt_cnt;
   } stat_type;

endpackage

// ----- hdl/positional_array_list.sv -----
// Top level of the positional array list: controller plus datapath.
// Depends on pal_pkg, pal_ctrl and pal_dpath.
//
//   channel  ports                              word
//   request  req_valid, req_ready, req_data     req_type (kind, value, position)
//   result   rsp_valid, rsp_ready, rsp_data     rsp_type (status, found, read_value,
//                                               element_count)
//
// Pop back and a refused request move no words, read makes one memory read, and
// insert, append, push front and deletes move n words; search compares every held word.
// Every element move and compare goes through the element memory, which has one
// read port and one write port, one read and one write per step.
// Reset clears the count; the memory is not cleared.
// A finished result waits in the output register; the next word is taken while
// it waits, and is held in its last state until the output register frees.
`timescale 1ns / 1ps

module positional_array_list
   import pal_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pal_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- hdl/pal_dpath.sv -----
// Datapath of the positional array list: element memory, count, pointer, request
// and result registers. Driven by pal_ctrl commands. Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_dpath
   import pal_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int POS_W = 8;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic signed [31:0] mem [DEPTH];

   req_type            req_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   tgt_ff, tgt_in;
   logic signed [31:0] rdata_ff;
   status_type         status_ff;
   logic               found_ff;
   logic signed [31:0] rd_ff;
   rsp_type            rsp_ff;

   logic [CMP_W-1:0]   pos_ext, cnt_ext;
   logic [CNT_W-1:0]   posm1;
   logic [CNT_W-1:0]   rd_addr;

   // Position checks against the current count
   assign pos_ext = CMP_W'(req_ff.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign posm1   = CNT_W'(pos_ext - CMP_W'(1));

   always_comb begin
      stat.kind          = req_ff.kind;
      stat.full          = (count_ff == CNT_W'(DEPTH));
      stat.empty         = (count_ff == '0);
      stat.ins_pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
      stat.del_pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
      stat.ptr_gt_tgt    = (ptr_ff > tgt_ff);
      stat.ptr_p1_lt_cnt = ({1'b0, ptr_ff} + (CNT_W + 1)'(1)) < {1'b0, count_ff};
      stat.ptr_lt_cnt    = (ptr_ff < count_ff);
   end

   // Select pointer, target and read address
   always_comb begin
      unique case (cmd.ptr_sel)
         SEL_COUNT: ptr_in = count_ff;
         SEL_ZERO:  ptr_in = '0;
         SEL_POSM1: ptr_in = posm1;
         default:   ptr_in = '0;
      endcase
      if (!cmd.ptr_load) begin
         if (cmd.ptr_inc) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end else if (cmd.ptr_dec) begin
            ptr_in = ptr_ff - CNT_W'(1);
         end else begin
            ptr_in = ptr_ff;
         end
      end

      unique case (cmd.tgt_sel)
         SEL_COUNT: tgt_in = count_ff;
         SEL_ZERO:  tgt_in = '0;
         SEL_POSM1: tgt_in = posm1;
         default:   tgt_in = '0;
      endcase
      if (!cmd.tgt_load) begin
         tgt_in = tgt_ff;
      end

      unique case (cmd.rd_sel)
         RD_PTR_M1: rd_addr = ptr_ff - CNT_W'(1);
         RD_PTR_P1: rd_addr = ptr_ff + CNT_W'(1);
         RD_PTR:    rd_addr = ptr_ff;
         RD_POSM1:  rd_addr = posm1;
         default:   rd_addr = ptr_ff;
      endcase

      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Count is the only register here with a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Element memory: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[ptr_ff[IDX_W-1:0]] <= cmd.wr_value ? req_ff.value : rdata_ff;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   // Request, pointer and result fields
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      tgt_ff <= tgt_in;
      if (cmd.load_req) begin
         req_ff    <= req_data;
         status_ff <= ST_OK;
         found_ff  <= 1'b0;
         rd_ff     <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.cmp_en && (rdata_ff == req_ff.value)) begin
            found_ff <= 1'b1;
         end
         if (cmd.rd_capture) begin
            rd_ff <= rdata_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.found         <= found_ff;
         rsp_ff.read_value    <= rd_ff;
         rsp_ff.element_count <= 7'(count_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hdl/pal_ctrl.sv -----
// Controller of the positional array list: sequences shifts, scans and reads
// over the datapath and runs both handshakes. Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_ctrl
   import pal_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end

         S_DECIDE: begin
            unique case (stat.kind)
               KIND_APPEND, KIND_PUSH_FRONT, KIND_INSERT_AT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                     state_in        = S_FINISH;
                  end else if ((stat.kind == KIND_INSERT_AT) && !stat.ins_pos_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_RANGE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.tgt_load = 1'b1;
                     cmd.tgt_sel  = (stat.kind == KIND_APPEND)     ? SEL_COUNT :
                                    (stat.kind == KIND_PUSH_FRONT) ? SEL_ZERO : SEL_POSM1;
                     cmd.ptr_load = 1'b1;
                     cmd.ptr_sel  = SEL_COUNT;
                     state_in     = S_UP_TEST;
                  end
               end
               KIND_POP_FRONT, KIND_DELETE_AT: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                     state_in        = S_FINISH;
                  end else if ((stat.kind == KIND_DELETE_AT) && !stat.del_pos_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_RANGE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.ptr_load = 1'b1;
                     cmd.ptr_sel  = (stat.kind == KIND_POP_FRONT) ? SEL_ZERO : SEL_POSM1;
                     state_in     = S_DN_TEST;
                  end
               end
               KIND_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               KIND_SEARCH: begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_sel  = SEL_ZERO;
                  state_in     = S_SC_TEST;
               end
               KIND_READ: begin
                  if (!stat.del_pos_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_RANGE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RD_POSM1;
                     state_in   = S_RD_WAIT;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end

         // Open a gap: move words up one place from the back down to the target
         S_UP_TEST: begin
            if (stat.ptr_gt_tgt) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_PTR_M1;
               state_in   = S_UP_WR;
            end else begin
               cmd.mem_wr   = 1'b1;
               cmd.wr_value = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in     = S_FINISH;
            end
         end

         S_UP_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_in    = S_UP_TEST;
         end

         // Close a gap: move words down one place toward the front
         S_DN_TEST: begin
            if (stat.ptr_p1_lt_cnt) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_PTR_P1;
               state_in   = S_DN_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end

         S_DN_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = S_DN_TEST;
         end

         // Scan held words for a match
         S_SC_TEST: begin
            if (stat.ptr_lt_cnt) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_PTR;
               state_in   = S_SC_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_SC_CMP: begin
            cmd.cmp_en  = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = S_SC_TEST;
         end

         S_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_FINISH;
         end

         // Hand the result word to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule
